>>> design/tq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer queue package
// Shared widths, opcodes, list entry, memory request, result and state types.
// ----------------------------------------------------------------------------
package tq_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int CNT_BITS   = $clog2(SLOTS + 1);
   localparam int TIME_WIDTH = 31;
   localparam int ID_WIDTH   = 4;
   localparam int NUM_IDS    = 16;
   localparam int OP_WIDTH   = 2;
   localparam int AMT_WIDTH  = 31;

   localparam int REQ_TDATA_WIDTH = 40;
   localparam int REQ_PAD         = REQ_TDATA_WIDTH - (ID_WIDTH + AMT_WIDTH);
   localparam int RSP_TDATA_WIDTH = 40;
   localparam int RSP_PAD         = RSP_TDATA_WIDTH - (ID_WIDTH + 2 + AMT_WIDTH);

   localparam logic [OP_WIDTH-1:0] OP_SUBMIT = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_TICK   = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_CANCEL = 2'd2;

   typedef struct packed {
      logic [ID_WIDTH-1:0]   id;
      logic [TIME_WIDTH-1:0] wait_us;
   } entry_type;

   typedef struct packed {
      logic                 rd_en;
      logic [SLOT_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [SLOT_BITS-1:0] wr_addr;
      entry_type            wr_data;
   } mem_req_type;

   typedef struct packed {
      logic                  expired_valid;
      logic [ID_WIDTH-1:0]   expired_id;
      logic                  last;
      logic                  was_pending;
      logic                  head_valid;
      logic [TIME_WIDTH-1:0] head_wait;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RM_RD,
      ST_RM_CHK,
      ST_RM_END,
      ST_INS_RD,
      ST_INS_CHK,
      ST_INS_END,
      ST_TK_RD,
      ST_TK_SUB,
      ST_HEAD_RD,
      ST_HEAD_WAIT,
      ST_SINGLE,
      ST_EM_RD,
      ST_EM_OUT
   } state_type;

   function automatic logic [AMT_WIDTH-1:0] to_port_time(input logic [TIME_WIDTH-1:0] t);
      return AMT_WIDTH'(t);
   endfunction

endpackage

>>> design/tq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer queue list store
// Ring of list entries, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tq_store (
   input  logic                clock,
   input  tq_pkg::mem_req_type mem_req,
   output tq_pkg::entry_type   rd_data
);

   tq_pkg::entry_type mem_ff [tq_pkg::SLOTS];
   tq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      // hold read data until the next read so a stalled result stays put
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/tq_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer queue subtract unit
// One subtractor: saturating a - b, and b > a from its borrow.
// ----------------------------------------------------------------------------
module tq_alu (
   input  logic [tq_pkg::TIME_WIDTH-1:0] a,
   input  logic [tq_pkg::TIME_WIDTH-1:0] b,
   output logic                          b_gt_a,
   output logic [tq_pkg::TIME_WIDTH-1:0] sat_diff
);

   logic [tq_pkg::TIME_WIDTH:0] diff;

   assign diff     = {1'b0, a} - {1'b0, b};
   assign b_gt_a   = diff[tq_pkg::TIME_WIDTH];
   assign sat_diff = b_gt_a ? '0 : diff[tq_pkg::TIME_WIDTH-1:0];

endmodule

>>> design/tq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer queue sequencer
// Walk the sorted ring entry by entry for remove, insert and tick.
// ----------------------------------------------------------------------------
module tq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tq_pkg::OP_WIDTH-1:0]   req_opcode,
   input  logic [tq_pkg::ID_WIDTH-1:0]   req_id,
   input  logic [tq_pkg::TIME_WIDTH-1:0] req_amt,
   output logic                          res_valid,
   input  logic                          res_ready,
   output tq_pkg::result_type            res,
   output tq_pkg::mem_req_type           mem_req,
   input  tq_pkg::entry_type             rd_data,
   output logic [tq_pkg::TIME_WIDTH-1:0] alu_b,
   input  logic                          alu_b_gt_a,
   input  logic [tq_pkg::TIME_WIDTH-1:0] alu_sat
);

   tq_pkg::state_type                state_ff, state_in;
   logic [tq_pkg::OP_WIDTH-1:0]      op_ff, op_in;
   logic [tq_pkg::ID_WIDTH-1:0]      id_ff, id_in;
   logic [tq_pkg::TIME_WIDTH-1:0]    amt_ff, amt_in;
   logic [tq_pkg::CNT_BITS-1:0]      idx_ff, idx_in;
   logic [tq_pkg::CNT_BITS-1:0]      zcnt_ff, zcnt_in;
   logic [tq_pkg::CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [tq_pkg::SLOT_BITS-1:0]     hd_ff, hd_in;
   logic [tq_pkg::NUM_IDS-1:0]       mark_ff, mark_in;
   logic                             found_ff, found_in;
   logic                             wp_ff, wp_in;
   logic                             headv_ff, headv_in;
   logic [tq_pkg::TIME_WIDTH-1:0]    headt_ff, headt_in;
   logic [tq_pkg::SLOT_BITS-1:0]     addr_idx, addr_prev;
   logic [tq_pkg::CNT_BITS-1:0]      idx_prev;
   logic                             em_last;

   assign idx_prev  = idx_ff - tq_pkg::CNT_BITS'(1);
   assign addr_idx  = hd_ff + idx_ff[tq_pkg::SLOT_BITS-1:0];
   assign addr_prev = hd_ff + idx_prev[tq_pkg::SLOT_BITS-1:0];
   assign em_last   = (idx_ff + tq_pkg::CNT_BITS'(1)) == zcnt_ff;
   assign alu_b     = amt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tq_pkg::ST_IDLE;
         cnt_ff   <= '0;
         hd_ff    <= '0;
         mark_ff  <= '0;
         headv_ff <= 1'b0;
         headt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         hd_ff    <= hd_in;
         mark_ff  <= mark_in;
         headv_ff <= headv_in;
         headt_ff <= headt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      id_ff    <= id_in;
      amt_ff   <= amt_in;
      idx_ff   <= idx_in;
      zcnt_ff  <= zcnt_in;
      found_ff <= found_in;
      wp_ff    <= wp_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      id_in     = id_ff;
      amt_in    = amt_ff;
      idx_in    = idx_ff;
      zcnt_in   = zcnt_ff;
      cnt_in    = cnt_ff;
      hd_in     = hd_ff;
      mark_in   = mark_ff;
      found_in  = found_ff;
      wp_in     = wp_ff;
      headv_in  = headv_ff;
      headt_in  = headt_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      mem_req   = '0;

      res.expired_valid = 1'b0;
      res.expired_id    = '0;
      res.last          = 1'b1;
      res.was_pending   = wp_ff;
      res.head_valid    = headv_ff;
      res.head_wait     = headt_ff;

      unique case (state_ff)
         tq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_opcode;
               id_in    = req_id;
               amt_in   = req_amt;
               idx_in   = '0;
               zcnt_in  = '0;
               found_in = 1'b0;
               wp_in    = 1'b0;
               case (req_opcode) inside
                  tq_pkg::OP_SUBMIT, tq_pkg::OP_CANCEL: begin
                     wp_in = mark_ff[req_id];
                     if (mark_ff[req_id]) begin
                        state_in = tq_pkg::ST_RM_RD;
                     end else if (req_opcode == tq_pkg::OP_SUBMIT &&
                                  cnt_ff < tq_pkg::CNT_BITS'(tq_pkg::SLOTS)) begin
                        idx_in   = cnt_ff;
                        state_in = tq_pkg::ST_INS_RD;
                     end else begin
                        state_in = tq_pkg::ST_HEAD_RD;
                     end
                  end
                  tq_pkg::OP_TICK: begin
                     state_in = tq_pkg::ST_TK_RD;
                  end
                  default: begin
                     state_in = tq_pkg::ST_HEAD_RD;
                  end
               endcase
            end
         end

         // remove: scan for the id, then pull every later entry down by one
         tq_pkg::ST_RM_RD: begin
            if (idx_ff < cnt_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = addr_idx;
               state_in        = tq_pkg::ST_RM_CHK;
            end else begin
               state_in = tq_pkg::ST_RM_END;
            end
         end

         tq_pkg::ST_RM_CHK: begin
            if (found_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = addr_prev;
               mem_req.wr_data = rd_data;
            end else if (rd_data.id == id_ff) begin
               found_in = 1'b1;
            end
            idx_in   = idx_ff + tq_pkg::CNT_BITS'(1);
            state_in = tq_pkg::ST_RM_RD;
         end

         tq_pkg::ST_RM_END: begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - tq_pkg::CNT_BITS'(1);
            end
            mark_in[id_ff] = 1'b0;
            if (op_ff == tq_pkg::OP_SUBMIT) begin
               idx_in   = cnt_in;
               state_in = tq_pkg::ST_INS_RD;
            end else begin
               state_in = tq_pkg::ST_HEAD_RD;
            end
         end

         // insert: walk down from the tail, shifting up until the slot fits
         tq_pkg::ST_INS_RD: begin
            if (idx_ff == '0) begin
               mem_req.wr_en           = 1'b1;
               mem_req.wr_addr         = addr_idx;
               mem_req.wr_data.id      = id_ff;
               mem_req.wr_data.wait_us = amt_ff;
               state_in                = tq_pkg::ST_INS_END;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = addr_prev;
               state_in        = tq_pkg::ST_INS_CHK;
            end
         end

         tq_pkg::ST_INS_CHK: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = addr_idx;
            if (alu_b_gt_a) begin
               mem_req.wr_data.id      = id_ff;
               mem_req.wr_data.wait_us = amt_ff;
               state_in                = tq_pkg::ST_INS_END;
            end else begin
               mem_req.wr_data = rd_data;
               idx_in          = idx_prev;
               state_in        = tq_pkg::ST_INS_RD;
            end
         end

         tq_pkg::ST_INS_END: begin
            cnt_in         = cnt_ff + tq_pkg::CNT_BITS'(1);
            mark_in[id_ff] = 1'b1;
            state_in       = tq_pkg::ST_HEAD_RD;
         end

         // tick: saturate every entry down; expired ones form a prefix
         tq_pkg::ST_TK_RD: begin
            if (idx_ff < cnt_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = addr_idx;
               state_in        = tq_pkg::ST_TK_SUB;
            end else begin
               state_in = tq_pkg::ST_HEAD_RD;
            end
         end

         tq_pkg::ST_TK_SUB: begin
            mem_req.wr_en           = 1'b1;
            mem_req.wr_addr         = addr_idx;
            mem_req.wr_data.id      = rd_data.id;
            mem_req.wr_data.wait_us = alu_sat;
            if (alu_sat == '0) begin
               zcnt_in = zcnt_ff + tq_pkg::CNT_BITS'(1);
            end
            idx_in   = idx_ff + tq_pkg::CNT_BITS'(1);
            state_in = tq_pkg::ST_TK_RD;
         end

         // head after the step sits just past the expired prefix
         tq_pkg::ST_HEAD_RD: begin
            idx_in = '0;
            if (cnt_ff > zcnt_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = hd_ff + zcnt_ff[tq_pkg::SLOT_BITS-1:0];
               state_in        = tq_pkg::ST_HEAD_WAIT;
            end else begin
               headv_in = 1'b0;
               headt_in = '0;
               state_in = (zcnt_ff != '0) ? tq_pkg::ST_EM_RD : tq_pkg::ST_SINGLE;
            end
         end

         tq_pkg::ST_HEAD_WAIT: begin
            headv_in = 1'b1;
            headt_in = rd_data.wait_us;
            state_in = (zcnt_ff != '0) ? tq_pkg::ST_EM_RD : tq_pkg::ST_SINGLE;
         end

         tq_pkg::ST_SINGLE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = tq_pkg::ST_IDLE;
            end
         end

         tq_pkg::ST_EM_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = addr_idx;
            state_in        = tq_pkg::ST_EM_OUT;
         end

         tq_pkg::ST_EM_OUT: begin
            res_valid         = 1'b1;
            res.expired_valid = 1'b1;
            res.expired_id    = rd_data.id;
            res.last          = em_last;
            res.was_pending   = 1'b0;
            if (res_ready) begin
               mark_in[rd_data.id] = 1'b0;
               if (em_last) begin
                  // drop the expired prefix by advancing the ring head
                  hd_in    = hd_ff + zcnt_ff[tq_pkg::SLOT_BITS-1:0];
                  cnt_in   = cnt_ff - zcnt_ff;
                  state_in = tq_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + tq_pkg::CNT_BITS'(1);
                  state_in = tq_pkg::ST_EM_RD;
               end
            end
         end

         default: begin
            state_in = tq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/sorted_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue
// Up to 16 timers kept in a ring sorted by remaining time; submit, tick and
// cancel walk the ring through one subtractor under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | ports  | direction | carries
//  --------+--------+-----------+------------------------------------------
//  request | req_*  | in        | opcode on tuser, task id and amount on tdata
//  result  | rsp_*  | out       | expiry, pending and head state; tlast ends
//
//  Passes: each pass over the list visits stored timers one at a time, with
//  a registered read of the list memory, then one compare/subtract and write.
//  Submit of a pending id runs a remove pass and an insert pass; tick runs
//  one pass plus a read and a result per expired timer; every op adds a
//  head lookup and a result.
//  Reset: synchronous; empties the list at once (count, ring head, marks).
//  Stalls: a held result blocks the sequencer; no request is taken until
//  the last result of the current one has been transferred into the output
//  register.
//
module sorted_timer_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // task_id[3:0], amount_us[34:4], zero fill
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // expired_id[3:0], was_pending[4],
                                    // head_valid[5], head_wait_us[36:6], zero fill
   output logic        rsp_tuser,   // expired_valid
   output logic        rsp_tlast
);

   tq_pkg::mem_req_type              mem_req;
   tq_pkg::entry_type                rd_data;
   tq_pkg::result_type               res;
   tq_pkg::result_type               rsp_ff;
   logic                             rsp_valid_ff;
   logic                             res_valid;
   logic                             res_ready;
   logic [tq_pkg::TIME_WIDTH-1:0]    alu_b;
   logic                             alu_b_gt_a;
   logic [tq_pkg::TIME_WIDTH-1:0]    alu_sat;
   logic [tq_pkg::ID_WIDTH-1:0]      req_id;
   logic [tq_pkg::TIME_WIDTH-1:0]    req_amt;

   // unpack the request; only the low TIME_WIDTH bits of the amount count
   assign req_id  = req_tdata[tq_pkg::ID_WIDTH-1:0];
   assign req_amt = req_tdata[tq_pkg::ID_WIDTH +: tq_pkg::TIME_WIDTH];

   tq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // shared subtractor: compare on insert, saturating decrement on tick
   tq_alu u_alu (
      .a        (rd_data.wait_us),
      .b        (alu_b),
      .b_gt_a   (alu_b_gt_a),
      .sat_diff (alu_sat)
   );

   tq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_opcode (req_tuser),
      .req_id     (req_id),
      .req_amt    (req_amt),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .alu_b      (alu_b),
      .alu_b_gt_a (alu_b_gt_a),
      .alu_sat    (alu_sat)
   );

   // output register: load when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.expired_valid;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {{tq_pkg::RSP_PAD{1'b0}},
                        tq_pkg::to_port_time(rsp_ff.head_wait),
                        rsp_ff.head_valid,
                        rsp_ff.was_pending,
                        rsp_ff.expired_id};

endmodule
